// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== rtl/mks_pkg.sv =====
package mks_pkg;

  localparam int unsigned MaxRows = 4;
  localparam int unsigned MaxCols = 4;

  localparam int unsigned ColW   = 4;
  localparam int unsigned RowW   = 4;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned TicksW = 16;

  localparam logic [TicksW-1:0] DebounceTicksRst = 16'd1000;
  localparam logic [CodeW-1:0]  DefaultKeyRst    = 8'd0;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CfgDebounceTicks = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgDefaultKey    = 8'd1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CodeW-1:0] AsciiZero = 8'h30;
  localparam logic [CodeW-1:0] AsciiA    = 8'h41;

  typedef enum logic [2:0] {
    PH_REL_WAIT = 3'd0,
    PH_REL_DEB  = 3'd1,
    PH_PRE_WAIT = 3'd2,
    PH_PRE_DEB  = 3'd3,
    PH_SCAN     = 3'd4
  } phase_e;

  typedef struct packed {
    logic [RowW-1:0]  row_drive;
    logic             key_valid;
    logic [CodeW-1:0] key_code;
  } mks_result_t;

  function automatic logic [CodeW-1:0] hex_ascii(input logic [3:0] v);
    logic [CodeW-1:0] r;
    if (v < 4'd10) begin
      r = AsciiZero + {4'd0, v};
    end else begin
      r = AsciiA + {4'd0, v - 4'd10};
    end
    return r;
  endfunction

endpackage

// ===== rtl/mks_fsm.sv =====
module mks_fsm #(
  parameter int unsigned ROWS = 4,
  parameter int unsigned COLS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [mks_pkg::ColW-1:0]       columns_i,
  input  logic [mks_pkg::TicksW-1:0]     debounce_ticks_i,
  input  logic [mks_pkg::CodeW-1:0]      default_key_i,
  output mks_pkg::mks_result_t           result_o
);
  import mks_pkg::*;

  localparam logic [ColW-1:0] ColMask = ColW'((1 << COLS) - 1);
  localparam logic [RowW-1:0] RowMask = RowW'((1 << ROWS) - 1);
  localparam logic [2:0]      RowsLim = 3'(ROWS);

  phase_e            phase_q, phase_d;
  logic [TicksW-1:0] count_q, count_d;
  logic [1:0]        row_q, row_d;

  logic [ColW-1:0] cols;
  logic            all_high;
  logic [1:0]      low_col;
  logic            below;

  always_comb begin
    cols     = columns_i & ColMask;
    all_high = (cols == ColMask);
    below    = (count_q < debounce_ticks_i);
    // Search from the top so that the lowest low column wins.
    low_col = '0;
    for (int j = COLS - 1; j >= 0; j--) begin
      if (!cols[j]) begin
        low_col = 2'(j);
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    row_d   = row_q;
    result_o.key_valid = 1'b0;
    result_o.key_code  = '0;
    unique case (phase_q)
      PH_REL_DEB: begin
        if (below) begin
          count_d = count_q + TicksW'(1);
        end else begin
          phase_d = all_high ? PH_PRE_WAIT : PH_REL_WAIT;
        end
      end
      PH_PRE_WAIT: begin
        if (!all_high) begin
          phase_d = PH_PRE_DEB;
          count_d = '0;
        end
      end
      PH_PRE_DEB: begin
        if (below) begin
          count_d = count_q + TicksW'(1);
        end else if (!all_high) begin
          phase_d = PH_SCAN;
          row_d   = '0;
        end else begin
          phase_d = PH_PRE_WAIT;
        end
      end
      PH_SCAN: begin
        if (!all_high) begin
          result_o.key_valid = 1'b1;
          result_o.key_code  = hex_ascii({row_q, low_col});
          phase_d = PH_REL_WAIT;
          row_d   = '0;
        end else if (({1'b0, row_q} + 3'd1) >= RowsLim) begin
          result_o.key_valid = 1'b1;
          result_o.key_code  = default_key_i;
          phase_d = PH_REL_WAIT;
          row_d   = '0;
        end else begin
          row_d = row_q + 2'd1;
        end
      end
      default: begin
        phase_d = PH_REL_WAIT;
        if (all_high) begin
          phase_d = PH_REL_DEB;
          count_d = '0;
        end
      end
    endcase
    if (phase_d == PH_SCAN) begin
      result_o.row_drive = ~(RowW'(1) << row_d) & RowMask;
    end else begin
      result_o.row_drive = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_REL_WAIT;
      count_q <= '0;
      row_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      row_q   <= row_d;
    end
  end

endmodule

// ===== rtl/matrix_keypad_scanner_top.sv =====
// A result appears on the master side in the cycle after its tick is accepted.
// Throughput: one tick per cycle while the master side takes results; a new tick is
// taken while the held result is being read, and input stalls while it waits unread.
// Reset: asynchronous, active low; phase returns to waiting for release, counters clear,
// debounce_ticks returns to 1000 and default_key to 0.
module matrix_keypad_scanner_top #(
  parameter int unsigned ROWS = mks_pkg::MaxRows,
  parameter int unsigned COLS = mks_pkg::MaxCols
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [3:0] column_levels
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // [3:0] row_drive, [11:4] key_code
  output logic                          m_axis_tuser,  // [0] key_valid
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mks_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mks_pkg::CfgDataW-1:0]  cfg_data_i
);
  import mks_pkg::*;

  logic [TicksW-1:0] debounce_ticks_q;
  logic [CodeW-1:0]  default_key_q;
  logic              in_take;
  mks_result_t       result;
  mks_result_t       out_q;
  logic              out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= DebounceTicksRst;
      default_key_q    <= DefaultKeyRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDebounceTicks: debounce_ticks_q <= cfg_data_i[TicksW-1:0];
        CfgDefaultKey:    default_key_q    <= cfg_data_i[CodeW-1:0];
        default: ;
      endcase
    end
  end

  // The output register frees up in the same cycle its transaction completes.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  mks_fsm #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_fsm (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (in_take),
    .columns_i        (s_axis_tdata[ColW-1:0]),
    .debounce_ticks_i (debounce_ticks_q),
    .default_key_i    (default_key_q),
    .result_o         (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.key_code, out_q.row_drive};
  assign m_axis_tuser  = out_q.key_valid;

`include "assert_macros.svh"

  `ASSERT_CLK(a_take_fills_out, in_take |=> out_valid_q, "accepted tick left no result")
  `ASSERT_NEVER(a_report_rows_low, out_valid_q && out_q.key_valid && (out_q.row_drive != '0), "rows driven on a key report")
  `ASSERT_NEVER(a_idle_code_zero, out_valid_q && !out_q.key_valid && (out_q.key_code != '0), "code without a key report")
  `ASSERT_NEVER(a_one_row_scanned, out_valid_q && (out_q.row_drive != '0) && ($countones(out_q.row_drive) != (ROWS - 1)), "scan drives more than one row low")

endmodule

// ===== tb/matrix_keypad_scanner_top_test.sv =====
`timescale 1ns / 1ps

module matrix_keypad_scanner_top_test;
  import mks_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 300;

  localparam logic [3:0] ColMask = 4'((1 << MaxCols) - 1);
  localparam logic [3:0] RowMask = 4'((1 << MaxRows) - 1);

  // An index past the register list; the block must ignore the write.
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 8'd2;

  localparam logic [CodeW-1:0] DigitZero = "0";
  localparam logic [CodeW-1:0] LetterA   = "A";
  localparam logic [CodeW-1:0] LetterF   = "F";

  localparam mks_result_t NoKey = '{row_drive: 4'h0, key_valid: 1'b0, key_code: 8'h00};

  typedef enum logic {
    ROW_TICK,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    logic [ColW-1:0]      cols;
    logic                 typed;
    mks_result_t          want;
  } dir_row_t;

  localparam int unsigned NumDirRows = 30;

  // Reset settings first, then a zero debounce so every phase is reached in a few ticks.
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'h0, 1'b1, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hF, 1'b1, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'h0, 1'b1, NoKey},
    '{ROW_CFG,  CfgDebounceTicks, 16'h0000, 4'h0, 1'b0, NoKey},
    '{ROW_CFG,  CfgDefaultKey,    16'h00FF, 4'h0, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hF, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hF, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hE, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hE, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hE, 1'b1, '{4'h0, 1'b1, DigitZero}},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hF, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'h5, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hF, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hF, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'h7, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hF, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'h0, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'h0, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hF, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hF, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hF, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hF, 1'b1, '{4'h0, 1'b1, 8'hFF}},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hF, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hF, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'h8, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'h8, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hF, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hF, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'hF, 1'b0, NoKey},
    '{ROW_TICK, CfgDebounceTicks, 16'h0000, 4'h7, 1'b1, '{4'h0, 1'b1, LetterF}}
  };

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index     = '0;
  logic [CfgDataW-1:0] cfg_data      = '0;

  // Scanner state as the testbench sees it.
  phase_e              scan_phase      = PH_REL_WAIT;
  logic [TicksW-1:0]   settle_cnt      = '0;
  logic [1:0]          scan_row_idx    = '0;
  logic [TicksW-1:0]   debounce_cfg    = DebounceTicksRst;
  logic [CodeW-1:0]    default_key_cfg = DefaultKeyRst;

  mks_result_t         pending_scan_out_q[$];

  int unsigned         error_cnt     = 0;
  int unsigned         ticks_sent    = 0;
  int unsigned         cycle_cnt     = 0;
  int unsigned         send_idle_pct = 14;
  int unsigned         recv_idle_pct = 50;
  int unsigned         hold_left     = 0;
  logic                hold_req      = 1'b0;

  matrix_keypad_scanner_top u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("matrix_keypad_scanner_top_test: done, errors");
      $finish;
    end
  end

  // Advances the scanner state by one tick and returns the output it causes.
  function automatic mks_result_t keypad_step(input logic [3:0] cols_in);
    logic [3:0]  cols;
    logic        all_high;
    logic [3:0]  key_idx;
    int unsigned j;
    mks_result_t res;
    cols     = cols_in & ColMask;
    all_high = (cols == ColMask);
    res      = NoKey;
    case (scan_phase)
      PH_REL_DEB: begin
        if (settle_cnt < debounce_cfg) begin
          settle_cnt++;
        end else begin
          scan_phase = all_high ? PH_PRE_WAIT : PH_REL_WAIT;
        end
      end
      PH_PRE_WAIT: begin
        if (!all_high) begin
          scan_phase = PH_PRE_DEB;
          settle_cnt = '0;
        end
      end
      PH_PRE_DEB: begin
        if (settle_cnt < debounce_cfg) begin
          settle_cnt++;
        end else if (!all_high) begin
          scan_phase   = PH_SCAN;
          scan_row_idx = '0;
        end else begin
          scan_phase = PH_PRE_WAIT;
        end
      end
      PH_SCAN: begin
        if (!all_high) begin
          j = 0;
          while (j < MaxCols && cols[j]) j++;
          key_idx       = {scan_row_idx, 2'(j)};
          res.key_valid = 1'b1;
          res.key_code  = (key_idx < 4'd10) ? DigitZero + {4'h0, key_idx}
                                            : LetterA + {4'h0, key_idx} - 8'd10;
          scan_phase    = PH_REL_WAIT;
          scan_row_idx  = '0;
        end else if (int'(scan_row_idx) + 1 >= MaxRows) begin
          res.key_valid = 1'b1;
          res.key_code  = default_key_cfg;
          scan_phase    = PH_REL_WAIT;
          scan_row_idx  = '0;
        end else begin
          scan_row_idx++;
        end
      end
      default: begin
        scan_phase = PH_REL_WAIT;
        if (all_high) begin
          scan_phase = PH_REL_DEB;
          settle_cnt = '0;
        end
      end
    endcase
    if (scan_phase == PH_SCAN) begin
      res.row_drive = ~(4'b0001 << scan_row_idx) & RowMask;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    error_cnt++;
  endtask

  // Entered and left at a falling edge.
  task automatic send_tick(input logic [3:0] cols, input logic typed = 1'b0,
                           input mks_result_t want = NoKey);
    mks_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, cols};
    do @(posedge clk); while (!s_axis_tready);
    predicted = keypad_step(cols);
    pending_scan_out_q.push_back(typed ? want : predicted);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    s_axis_tvalid <= 1'b0;
    while (pending_scan_out_q.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CfgDebounceTicks) begin
      debounce_cfg = data;
    end else if (idx == CfgDefaultKey) begin
      default_key_cfg = data[CodeW-1:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A release, a press and a scan, with random content in the debounce windows. A few
  // sequences bounce on the release or the press check, or trail off into noise.
  task automatic key_sequence();
    int unsigned flaw;
    int unsigned hit_row;
    int unsigned col;
    int unsigned hi_mask;
    flaw    = $urandom_range(0, 19);
    hit_row = $urandom_range(0, MaxRows);
    col     = $urandom_range(0, MaxCols - 1);
    hi_mask = (32'hF << (col + 1)) & 32'hF;
    send_tick(4'hF);
    repeat (debounce_cfg) send_tick(4'($urandom));
    if (flaw == 0) begin
      send_tick(4'($urandom_range(0, 14)));
      return;
    end
    send_tick(4'hF);
    repeat ($urandom_range(0, 2)) send_tick(4'hF);
    send_tick(4'($urandom_range(0, 14)));
    repeat (debounce_cfg) send_tick(4'($urandom));
    if (flaw == 1) begin
      send_tick(4'hF);
      return;
    end
    send_tick(4'($urandom_range(0, 14)));
    // Rows above the hit row read all high; no hit row at all gives the default key.
    for (int unsigned r = 0; r < hit_row; r++) send_tick(4'hF);
    if (hit_row < MaxRows) begin
      send_tick(4'(($urandom & hi_mask) | ((1 << col) - 1)));
    end
    if (flaw == 2) begin
      repeat ($urandom_range(1, 8)) send_tick($urandom_range(0, 1) ? 4'hF : 4'($urandom));
    end
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_out
    mks_result_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (pending_scan_out_q.size() == 0) begin
        report_mismatch("unexpected transaction", m_axis_tdata, 16'h0000);
      end else begin
        want = pending_scan_out_q.pop_front();
        if (m_axis_tdata[3:0] !== want.row_drive) begin
          report_mismatch("row_drive", 16'(m_axis_tdata[3:0]), 16'(want.row_drive));
        end
        if (m_axis_tuser !== want.key_valid) begin
          report_mismatch("key_valid", 16'(m_axis_tuser), 16'(want.key_valid));
        end
        if (m_axis_tdata[11:4] !== want.key_code) begin
          report_mismatch("key_code", 16'(m_axis_tdata[11:4]), 16'(want.key_code));
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int unsigned i = 0; i < NumDirRows; i++) begin
      if (DirRows[i].kind == ROW_CFG) begin
        write_cfg(DirRows[i].idx, DirRows[i].data);
      end else begin
        send_tick(DirRows[i].cols, DirRows[i].typed, DirRows[i].want);
      end
    end

    // Zero debounce; a full 16-bit write checks that only the low byte is kept.
    write_cfg(CfgDefaultKey, 16'($urandom));
    while (ticks_sent < 380) key_sequence();

    // The receiver holds off for a long stretch while ticks keep coming.
    write_cfg(CfgDebounceTicks, 16'($urandom_range(1, 4)));
    write_cfg(CfgDefaultKey, 16'h0000);
    send_idle_pct = 50;
    recv_idle_pct = 14;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    while (ticks_sent < 730) key_sequence();

    // Longest debounce: the release check is never reached, so only noise is useful here.
    write_cfg(CfgUnusedIdx, 16'($urandom));
    write_cfg(CfgDebounceTicks, 16'hFFFF);
    while (ticks_sent < 830) send_tick($urandom_range(0, 1) ? 4'hF : 4'($urandom));

    write_cfg(CfgDebounceTicks, 16'($urandom_range(0, 6)));
    write_cfg(CfgDefaultKey, 16'($urandom_range(0, 255)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (ticks_sent < 1280) key_sequence();

    s_axis_tvalid <= 1'b0;
    while (pending_scan_out_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_cnt == 0) begin
      $display("matrix_keypad_scanner_top_test: done, clean");
    end else begin
      $display("matrix_keypad_scanner_top_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mks_pkg.sv
rtl/mks_fsm.sv
rtl/matrix_keypad_scanner_top.sv
tb/matrix_keypad_scanner_top_test.sv
